// ===== hw/rtl/itscan_pkg.sv =====
// shared types and constants for the identifier token scanner
package itscan_pkg;

    // identifier count bound and derived counter width
    localparam int unsigned MAX_IDENTIFIERS = 256;
    localparam int unsigned CNT_W           = $clog2(MAX_IDENTIFIERS + 1);
    localparam int unsigned ORD_W           = 8;
    localparam int unsigned TOTAL_W         = 9;

    // character codes
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_IDENT    = 3'd1,
        MODE_NUMBER   = 3'd2,
        MODE_MEMBER   = 3'd3,
        MODE_DOT_SKIP = 3'd4,
        MODE_SQUOTE   = 3'd5,
        MODE_DQUOTE   = 3'd6
    } scan_mode_t;

    // input transaction
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic               starts_identifier;
        logic               inside_identifier;
        logic [ORD_W-1:0]   identifier_ordinal;
        logic [TOTAL_W-1:0] identifier_total;
        logic               overflow;
        logic               line_done;
    } out_item_t;

    // character classes
    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

// ===== hw/rtl/identifier_token_scanner.sv =====
// identifier token scanner: marks identifiers in a stream of line characters
//
// Usage: one character per input transaction on s_data (ch, end_of_line),
// one result per character on m_data, in order. Both channels are
// valid/ready; a transaction moves when valid and ready are both high.
// The result for a character is in the output register from the cycle
// after its input transaction, so m_valid rises on the next clock.
// Throughput: one character per clock unless the output stalls. The scan
// state is updated in the same cycle the character is accepted, through
// one level of mode logic and a counter increment, and the single output
// register is refilled while it is being drained.
// Stall: while m_valid is high and m_ready is low, s_ready is low and the
// held result and the scan state stay unchanged.
// Reset: synchronous, active low on aresetn; the scanner returns to normal
// mode with zero count and no overflow, and the output register empties.
// A character with end_of_line set ends the line: after its result the
// scanner state returns to its reset values.
module identifier_token_scanner (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  itscan_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output itscan_pkg::out_item_t m_data
);

    itscan_pkg::scan_mode_t              mode_reg, mode_next;
    logic                                after_id_reg, after_id_next;
    logic                                prev_digit_reg, prev_digit_next;
    logic                                dash_reg, dash_next;
    logic [itscan_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                                ovf_reg, ovf_next;
    logic                                m_valid_reg;
    itscan_pkg::out_item_t               m_data_reg, m_data_next;

    logic                                accept;
    logic                                dispatch;
    logic                                start;
    logic                                in_ident;
    logic                                c_letter, c_digit, c_alnum;
    logic [7:0]                          c;
    logic [itscan_pkg::CNT_W-1:0]        ord_full;

    // handshake: output register refills while it drains
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // character classes
    assign c        = s_data.ch;
    assign c_letter = itscan_pkg::is_letter(c);
    assign c_digit  = itscan_pkg::is_digit(c);
    assign c_alnum  = c_letter || c_digit;

    // next scan state and result for the incoming character
    always_comb begin
        mode_next       = mode_reg;
        after_id_next   = after_id_reg;
        dash_next       = 1'b0;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        prev_digit_next = c_digit;
        dispatch        = 1'b0;
        start           = 1'b0;
        in_ident        = 1'b0;

        // mode specific handling
        unique case (mode_reg)
            itscan_pkg::MODE_IDENT: begin
                if (c_alnum || c == itscan_pkg::CH_UNDER) begin
                    in_ident = 1'b1;
                end else begin
                    dispatch = 1'b1;
                end
            end
            itscan_pkg::MODE_NUMBER: begin
                if (!(c_alnum || c == itscan_pkg::CH_UNDER)) begin
                    dispatch = 1'b1;
                end
            end
            itscan_pkg::MODE_MEMBER: begin
                if (!c_alnum) begin
                    dispatch = 1'b1;
                end
            end
            itscan_pkg::MODE_DOT_SKIP: begin
                mode_next = itscan_pkg::MODE_MEMBER;
            end
            itscan_pkg::MODE_SQUOTE: begin
                if (c == itscan_pkg::CH_SQUOTE) begin
                    mode_next = itscan_pkg::MODE_NORMAL;
                end
            end
            itscan_pkg::MODE_DQUOTE: begin
                if (c == itscan_pkg::CH_DQUOTE) begin
                    mode_next = itscan_pkg::MODE_NORMAL;
                end
            end
            default: begin
                dispatch = 1'b1;
            end
        endcase

        // normal dispatch of a character
        if (dispatch) begin
            mode_next = itscan_pkg::MODE_NORMAL;
            if (c_letter && !prev_digit_reg) begin
                start    = 1'b1;
                in_ident = 1'b1;
                if (count_reg < itscan_pkg::CNT_W'(itscan_pkg::MAX_IDENTIFIERS)) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
                mode_next     = itscan_pkg::MODE_IDENT;
                after_id_next = 1'b1;
            end else if (c_digit) begin
                mode_next     = itscan_pkg::MODE_NUMBER;
                after_id_next = 1'b0;
            end else if (dash_reg && c == itscan_pkg::CH_GT) begin
                mode_next     = itscan_pkg::MODE_MEMBER;
                after_id_next = 1'b0;
            end else if (c == itscan_pkg::CH_DASH && after_id_reg) begin
                dash_next = 1'b1;
            end else if (c == itscan_pkg::CH_DOT && after_id_reg) begin
                mode_next     = itscan_pkg::MODE_DOT_SKIP;
                after_id_next = 1'b0;
            end else if (c == itscan_pkg::CH_SQUOTE) begin
                mode_next = itscan_pkg::MODE_SQUOTE;
            end else if (c == itscan_pkg::CH_DQUOTE) begin
                mode_next = itscan_pkg::MODE_DQUOTE;
            end
        end

        // result fields
        ord_full = count_next - 1'b1;
        m_data_next.starts_identifier  = start;
        m_data_next.inside_identifier  = in_ident;
        m_data_next.identifier_ordinal = (in_ident && count_next != '0)
                                         ? ord_full[itscan_pkg::ORD_W-1:0]
                                         : '0;
        m_data_next.identifier_total   = itscan_pkg::TOTAL_W'(count_next);
        m_data_next.overflow           = ovf_next;
        m_data_next.line_done          = s_data.end_of_line;
    end

    // scan state registers, cleared at end of line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= itscan_pkg::MODE_NORMAL;
            after_id_reg   <= 1'b0;
            prev_digit_reg <= 1'b0;
            dash_reg       <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
        end else if (accept) begin
            if (s_data.end_of_line) begin
                mode_reg       <= itscan_pkg::MODE_NORMAL;
                after_id_reg   <= 1'b0;
                prev_digit_reg <= 1'b0;
                dash_reg       <= 1'b0;
                count_reg      <= '0;
                ovf_reg        <= 1'b0;
            end else begin
                mode_reg       <= mode_next;
                after_id_reg   <= after_id_next;
                prev_digit_reg <= prev_digit_next;
                dash_reg       <= dash_next;
                count_reg      <= count_next;
                ovf_reg        <= ovf_next;
            end
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    // a starting character always lies inside its identifier
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.starts_identifier |-> m_data.inside_identifier)
        else $error("start flagged outside an identifier");

    // end of line returns the scanner to its reset state
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.end_of_line |=>
            mode_reg == itscan_pkg::MODE_NORMAL && count_reg == '0 && !ovf_reg)
        else $error("scanner state not cleared after end of line");

    // the identifier count never passes its bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= itscan_pkg::CNT_W'(itscan_pkg::MAX_IDENTIFIERS))
        else $error("identifier count beyond bound");

    // overflow only once the count sits at the bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> count_reg == itscan_pkg::CNT_W'(itscan_pkg::MAX_IDENTIFIERS))
        else $error("overflow raised below the bound");
`endif

endmodule

// ===== bench/tb_identifier_token_scanner.sv =====
// self-checking testbench for the identifier token scanner
`timescale 1ns / 1ps

module tb_identifier_token_scanner;

    // cycles without any transaction before the run is abandoned
    localparam int unsigned STALL_LIMIT = 4000;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    itscan_pkg::in_item_t  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    itscan_pkg::out_item_t m_data;

    // characters waiting to be sent and results still owed by the scanner
    itscan_pkg::in_item_t  char_queue[$];
    itscan_pkg::out_item_t expected_marks[$];
    logic [7:0]            line_buf[$];

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned error_count  = 0;
    int unsigned stall_cycles = 0;

    // shadow of the scanner state
    itscan_pkg::scan_mode_t sh_mode;
    logic                   sh_after_ident;
    logic                   sh_prev_digit;
    logic                   sh_pending_dash;
    int unsigned            sh_count;
    logic                   sh_overflow;

    identifier_token_scanner u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // character classes, ascii only
    function automatic logic letter_char(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (c < 8'h80) && (folded >= "a") && (folded <= "z");
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    task automatic clear_scan_state();
        sh_mode         = itscan_pkg::MODE_NORMAL;
        sh_after_ident  = 1'b0;
        sh_prev_digit   = 1'b0;
        sh_pending_dash = 1'b0;
        sh_count        = 0;
        sh_overflow     = 1'b0;
    endtask

    // work out the marks for one accepted character and queue them
    task automatic scan_character(input itscan_pkg::in_item_t item);
        itscan_pkg::out_item_t mark;
        logic [7:0] c;
        logic       begins;
        logic       in_ident;
        logic       redispatch;
        logic       dash_seen;
        logic       word;
        c          = item.ch;
        begins     = 1'b0;
        in_ident   = 1'b0;
        redispatch = 1'b0;
        dash_seen  = sh_pending_dash;
        word       = letter_char(c) || digit_char(c);
        sh_pending_dash = 1'b0;

        // continue the current mode
        case (sh_mode)
            itscan_pkg::MODE_IDENT: begin
                if (word || c == itscan_pkg::CH_UNDER) in_ident = 1'b1;
                else redispatch = 1'b1;
            end
            itscan_pkg::MODE_NUMBER: begin
                if (!(word || c == itscan_pkg::CH_UNDER)) redispatch = 1'b1;
            end
            itscan_pkg::MODE_MEMBER: begin
                if (!word) redispatch = 1'b1;
            end
            itscan_pkg::MODE_DOT_SKIP: sh_mode = itscan_pkg::MODE_MEMBER;
            itscan_pkg::MODE_SQUOTE: begin
                if (c == itscan_pkg::CH_SQUOTE) sh_mode = itscan_pkg::MODE_NORMAL;
            end
            itscan_pkg::MODE_DQUOTE: begin
                if (c == itscan_pkg::CH_DQUOTE) sh_mode = itscan_pkg::MODE_NORMAL;
            end
            default: redispatch = 1'b1;
        endcase

        // decide what this character opens
        if (redispatch) begin
            sh_mode = itscan_pkg::MODE_NORMAL;
            if (letter_char(c) && !sh_prev_digit) begin
                begins   = 1'b1;
                in_ident = 1'b1;
                if (sh_count < itscan_pkg::MAX_IDENTIFIERS) sh_count++;
                else sh_overflow = 1'b1;
                sh_mode        = itscan_pkg::MODE_IDENT;
                sh_after_ident = 1'b1;
            end else if (digit_char(c)) begin
                sh_mode        = itscan_pkg::MODE_NUMBER;
                sh_after_ident = 1'b0;
            end else if (dash_seen && c == itscan_pkg::CH_GT) begin
                sh_mode        = itscan_pkg::MODE_MEMBER;
                sh_after_ident = 1'b0;
            end else if (c == itscan_pkg::CH_DASH && sh_after_ident) begin
                sh_pending_dash = 1'b1;
            end else if (c == itscan_pkg::CH_DOT && sh_after_ident) begin
                sh_mode        = itscan_pkg::MODE_DOT_SKIP;
                sh_after_ident = 1'b0;
            end else if (c == itscan_pkg::CH_SQUOTE) begin
                sh_mode = itscan_pkg::MODE_SQUOTE;
            end else if (c == itscan_pkg::CH_DQUOTE) begin
                sh_mode = itscan_pkg::MODE_DQUOTE;
            end
        end
        sh_prev_digit = digit_char(c);

        mark.starts_identifier  = begins;
        mark.inside_identifier  = in_ident;
        mark.identifier_ordinal = (in_ident && sh_count > 0)
                                  ? itscan_pkg::ORD_W'(sh_count - 1) : '0;
        mark.identifier_total   = itscan_pkg::TOTAL_W'(sh_count);
        mark.overflow           = sh_overflow;
        mark.line_done          = item.end_of_line;
        expected_marks.push_back(mark);

        // end of line returns the scanner to its reset state
        if (item.end_of_line) clear_scan_state();
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // driver: one nonblocking update of valid per edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_scan_state();
        end else begin
            if (s_valid && s_ready) scan_character(s_data);
            if (!s_valid || s_ready) begin
                if (char_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_data  <= char_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        itscan_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_marks.size() == 0) begin
                report_mismatch("unexpected result transaction", 1, 0);
            end else begin
                want = expected_marks.pop_front();
                if (m_data.starts_identifier !== want.starts_identifier)
                    report_mismatch("starts_identifier", m_data.starts_identifier,
                                    want.starts_identifier);
                if (m_data.inside_identifier !== want.inside_identifier)
                    report_mismatch("inside_identifier", m_data.inside_identifier,
                                    want.inside_identifier);
                if (m_data.identifier_ordinal !== want.identifier_ordinal)
                    report_mismatch("identifier_ordinal", m_data.identifier_ordinal,
                                    want.identifier_ordinal);
                if (m_data.identifier_total !== want.identifier_total)
                    report_mismatch("identifier_total", m_data.identifier_total,
                                    want.identifier_total);
                if (m_data.overflow !== want.overflow)
                    report_mismatch("overflow", m_data.overflow, want.overflow);
                if (m_data.line_done !== want.line_done)
                    report_mismatch("line_done", m_data.line_done, want.line_done);
            end
        end
    end

    // watchdog on cycles with work outstanding but no transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (char_queue.size() == 0 && !s_valid && expected_marks.size() == 0)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // line building helpers
    task automatic flush_line();
        itscan_pkg::in_item_t item;
        while (line_buf.size() != 0) begin
            item.ch          = line_buf.pop_front();
            item.end_of_line = (line_buf.size() == 0);
            char_queue.push_back(item);
        end
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "A" : "a";
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_word_char();
        int unsigned r;
        r = $urandom_range(0, 62);
        if (r < 52) return rand_letter();
        if (r < 62) return "0" + 8'(r - 52);
        return itscan_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_separator();
        string seps;
        seps = " ,;()+*=[]{}/:!";
        return seps[$urandom_range(0, seps.len() - 1)];
    endfunction

    task automatic add_identifier();
        line_buf.push_back(rand_letter());
        repeat ($urandom_range(0, 6)) line_buf.push_back(rand_word_char());
    endtask

    // one token of a mostly well-formed line
    task automatic add_token();
        logic [7:0] q;
        case ($urandom_range(0, 9))
            0, 1: add_identifier();
            2: begin
                line_buf.push_back("0" + 8'($urandom_range(0, 9)));
                repeat ($urandom_range(0, 4)) line_buf.push_back(rand_word_char());
            end
            3, 4: line_buf.push_back(rand_separator());
            5: begin
                add_identifier();
                add_text("->");
                repeat ($urandom_range(0, 5)) line_buf.push_back(rand_word_char());
            end
            6: begin
                add_identifier();
                line_buf.push_back(itscan_pkg::CH_DOT);
                line_buf.push_back(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 5)) line_buf.push_back(rand_word_char());
            end
            7: begin
                q = $urandom_range(0, 1) ? itscan_pkg::CH_SQUOTE : itscan_pkg::CH_DQUOTE;
                line_buf.push_back(q);
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 3))
                        0: line_buf.push_back(itscan_pkg::CH_SQUOTE ^
                                              itscan_pkg::CH_DQUOTE ^ q);
                        1: line_buf.push_back(rand_separator());
                        default: line_buf.push_back(rand_word_char());
                    endcase
                end
                if ($urandom_range(0, 4) != 0) line_buf.push_back(q);
            end
            8: begin
                add_identifier();
                line_buf.push_back(itscan_pkg::CH_DASH);
                if ($urandom_range(0, 1)) line_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    // random lines totalling about the given number of characters
    task automatic add_random_lines(input int unsigned n_chars);
        int unsigned made;
        int unsigned target;
        made = 0;
        while (made < n_chars) begin
            target = $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0) begin
                // noise line of arbitrary bytes
                repeat (target) line_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                while (line_buf.size() < target) add_token();
            end
            made += line_buf.size();
            flush_line();
        end
    endtask

    task automatic wait_drained();
        while (char_queue.size() != 0 || s_valid || expected_marks.size() != 0)
            @(negedge aclk);
    endtask

    // stimulus and end of test
    initial begin
        tx_idle_pct = 19;
        rx_idle_pct = 77;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // dash without arrow, arrow member stopping at underscore
        add_text("p-q>x->m_k");
        flush_line();
        // dot skip takes a digit, then the member name
        add_text("y.5z");
        flush_line();
        // each quote closes only its own kind, double quote left open
        add_text("'\"'\"'");
        flush_line();
        // class boundaries and the byte extremes, word starting with a digit
        line_buf.push_back(8'h00);
        add_text("@A[`z{/9Az:");
        line_buf.push_back(8'hFF);
        flush_line();

        // counter saturation on one long line
        repeat (itscan_pkg::MAX_IDENTIFIERS + 2) begin
            line_buf.push_back(rand_letter());
            line_buf.push_back(rand_separator());
        end
        flush_line();

        add_random_lines(15);
        wait_drained();

        tx_idle_pct = 77;
        rx_idle_pct = 19;
        add_random_lines(15);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_lines(15);
        wait_drained();

        repeat (10) @(negedge aclk);
        if (error_count == 0 && expected_marks.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
